// ===== design/taw_pkg.sv =====
// taw_pkg: shared types and constants for the texel address wrap block.
// Depends on nothing; imported by texel_address_wrap, taw_chk and tb_top.
package taw_pkg;

    localparam int COORD_W    = 24;   // unsigned fixed-point coordinate
    localparam int INDEX_W    = 24;   // linear texel index
    localparam int CFG_SIZE_W = 13;   // width / height register
    localparam int CFG_IDX_W  = 2;    // register index on the config port
    localparam int MODE_W     = 2;
    localparam int LANES      = 2;    // u and v axes

    typedef enum logic [MODE_W-1:0] {
        WRAP_REPEAT = 2'd0,
        WRAP_MIRROR = 2'd1,
        WRAP_CLAMP  = 2'd2
    } t_wrap_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH  = 2'd0,
        REG_TEX_HEIGHT = 2'd1,
        REG_WRAP_MODE  = 2'd2
    } t_reg_idx;

    localparam logic [CFG_SIZE_W-1:0] RST_TEX_SIZE = 13'd2;
    localparam logic [MODE_W-1:0]     RST_MODE     = WRAP_CLAMP;

endpackage

// ===== design/texel_address_wrap.sv =====
// texel_address_wrap: texture coordinate pair to linear texel index.
// Throughput 1 item per cycle while the result side keeps taking items, set by a
// five-stage pipeline (scale multiply, round, wrap, row multiply, add) with one
// valid bit per stage and a ready chain for stalls.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads tex_width 2,
// tex_height 2, wrap mode clamp to edge. Depends on taw_pkg.
module texel_address_wrap
    import taw_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_SIZE_W-1:0] i_cfg_wdata,
    // input item channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_W-1:0]    i_coord_u,
    input  logic [COORD_W-1:0]    i_coord_v,
    // result item channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [INDEX_W-1:0]    o_texel_index
);

    // Effective size width: enough for MAX_DIM, never more than the register.
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int SIZE_W = (DIM_W < CFG_SIZE_W) ? DIM_W : CFG_SIZE_W;
    // Scaled fraction product, rounded value (may equal size), whole part + carry.
    localparam int PROD_W = FRAC_BITS + SIZE_W;
    localparam int RND_W  = SIZE_W + 1;
    localparam int K_W    = COORD_W - FRAC_BITS + 1;
    localparam int SUM_W  = 2 * SIZE_W + 1;
    localparam int STAGES = 5;

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_SIZE_W-1:0] r_tex_width;
    logic [CFG_SIZE_W-1:0] r_tex_height;
    logic [MODE_W-1:0]     r_wrap_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= RST_TEX_SIZE;
            r_tex_height <= RST_TEX_SIZE;
            r_wrap_mode  <= RST_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TEX_WIDTH:  r_tex_width  <= i_cfg_wdata;
                REG_TEX_HEIGHT: r_tex_height <= i_cfg_wdata;
                REG_WRAP_MODE:  r_wrap_mode  <= i_cfg_wdata[MODE_W-1:0];
                default: ;  // unknown register index: ignored
            endcase
        end
    end

    // Effective sizes: zero acts as one, anything above MAX_DIM as MAX_DIM.
    // The user must make sure config only changes while the pipeline is empty;
    // the block does not enforce it. The live values serve every stage.
    logic [SIZE_W-1:0] n_size [LANES];

    always_comb begin
        if (r_tex_width == '0) begin
            n_size[0] = SIZE_W'(1);
        end else if (32'(r_tex_width) > MAX_DIM) begin
            n_size[0] = SIZE_W'(MAX_DIM);
        end else begin
            n_size[0] = SIZE_W'(r_tex_width);
        end
        if (r_tex_height == '0) begin
            n_size[1] = SIZE_W'(1);
        end else if (32'(r_tex_height) > MAX_DIM) begin
            n_size[1] = SIZE_W'(MAX_DIM);
        end else begin
            n_size[1] = SIZE_W'(r_tex_height);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes a new item when it is empty or its
    // item moves on in the same cycle.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_rdy;

    always_comb begin
        n_rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            n_rdy[s] = !r_vld[s] || n_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (n_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready = n_rdy[0];
    assign o_valid = r_vld[STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: split each coordinate into whole and fraction parts and
    // scale the fraction by the axis size. round(c*size) = whole*size +
    // round(frac*size), so the wrap needs no divider.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] n_coord [LANES];
    logic [PROD_W-1:0]  r1_prod [LANES];
    logic [K_W-1:0]     r1_whole[LANES];

    assign n_coord[0] = i_coord_u;
    assign n_coord[1] = i_coord_v;

    always_ff @(posedge i_clk) begin
        if (n_rdy[0] && i_valid) begin
            for (int l = 0; l < LANES; l++) begin
                r1_prod[l]  <= PROD_W'(n_coord[l][FRAC_BITS-1:0]) * PROD_W'(n_size[l]);
                r1_whole[l] <= K_W'({1'b0, n_coord[l]} >> FRAC_BITS);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round half up. A rounded fraction equal to the size carries
    // into the whole part, leaving rem < size and t = k*size + rem.
    // ------------------------------------------------------------------
    logic [PROD_W:0]   n_rsum[LANES];
    logic [RND_W-1:0]  n_rnd [LANES];
    logic              n_hit [LANES];
    logic [SIZE_W-1:0] r2_rem[LANES];
    logic [K_W-1:0]    r2_k  [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_rsum[l] = (PROD_W + 1)'(r1_prod[l]) + HALF;
            n_rnd[l]  = n_rsum[l][PROD_W:FRAC_BITS];
            n_hit[l]  = (n_rnd[l] == RND_W'(n_size[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[1] && r_vld[0]) begin
            for (int l = 0; l < LANES; l++) begin
                r2_rem[l] <= n_hit[l] ? '0 : n_rnd[l][SIZE_W-1:0];
                r2_k[l]   <= n_hit[l] ? (r1_whole[l] + K_W'(1)) : r1_whole[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: wrap mode, same for both axes.
    //   repeat: rem; mirror: odd period reflects; clamp: past the edge
    //   pins to size-1. Mode code 3 behaves as clamp.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] n_wrap[LANES];
    logic [SIZE_W-1:0] r3_pos[LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (r_wrap_mode)
                WRAP_REPEAT: n_wrap[l] = r2_rem[l];
                WRAP_MIRROR: n_wrap[l] = r2_k[l][0]
                                       ? (n_size[l] - r2_rem[l] - SIZE_W'(1))
                                       : r2_rem[l];
                default:     n_wrap[l] = (r2_k[l] != '0)
                                       ? (n_size[l] - SIZE_W'(1))
                                       : r2_rem[l];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[2] && r_vld[1]) begin
            r3_pos <= n_wrap;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: row offset y * width.  Stage 5: add column, keep 24 bits.
    // ------------------------------------------------------------------
    logic [2*SIZE_W-1:0] r4_row;
    logic [SIZE_W-1:0]   r4_col;
    logic [INDEX_W-1:0]  r5_index;

    always_ff @(posedge i_clk) begin
        if (n_rdy[3] && r_vld[2]) begin
            r4_row <= (2 * SIZE_W)'(r3_pos[1]) * (2 * SIZE_W)'(n_size[0]);
            r4_col <= r3_pos[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[4] && r_vld[3]) begin
            r5_index <= INDEX_W'(SUM_W'(r4_row) + SUM_W'(r4_col));
        end
    end

    assign o_texel_index = r5_index;

endmodule

// ===== design/taw_chk.sv =====
// taw_chk: port-level checks for texel_address_wrap, attached by bind.
// Depends on taw_pkg.
module taw_chk
    import taw_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input logic [CFG_SIZE_W-1:0] i_cfg_wdata,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [COORD_W-1:0]    i_coord_u,
    input logic [COORD_W-1:0]    i_coord_v,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [INDEX_W-1:0]    o_texel_index
);

    // Reset leaves no item in flight.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Input side only backs up when the output holds a stalled item.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while output not blocked");

    // An accepted item reaches the output when the sink keeps taking.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid)
        else $error("item lost in pipeline");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_texel_index)))
        else $error("stalled result dropped or changed");

endmodule

bind texel_address_wrap taw_chk u_taw_chk (.*);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for texel_address_wrap, with a directed table, then random items.
// Expected indexes come from an in-bench predictor or a hand-typed table value; depends on taw_pkg and the DUT.
`timescale 1ns / 100ps

module tb_top;
    import taw_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int LATENCY      = 5;       // accept to result
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;     // receiver hold-off that backs up the pipe
    localparam int REPORT_MAX   = 10;

    // codes the package leaves unnamed: a spare mode and a spare register slot
    localparam logic [MODE_W-1:0]    WRAP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    localparam logic [COORD_W-1:0] C_MAX = 24'hFF_FFFF;
    localparam logic [INDEX_W-1:0] I_MAX = 24'hFF_FFFF;

    // one directed row: texture setup, coordinates, and a hand-typed index where obvious
    typedef struct packed {
        logic [CFG_SIZE_W-1:0] w;
        logic [CFG_SIZE_W-1:0] h;
        logic [MODE_W-1:0]     mode;
        logic [COORD_W-1:0]    u;
        logic [COORD_W-1:0]    v;
        logic                  known;
        logic [INDEX_W-1:0]    idx;
    } t_dir_row;

    localparam int DIR_N = 22;
    localparam t_dir_row DIRECTED [DIR_N] = '{
        // reset setup: 2x2, clamp to edge
        '{13'd2,    13'd2,    WRAP_CLAMP,  24'h000000, 24'h000000, 1'b1, 24'd0},
        '{13'd2,    13'd2,    WRAP_CLAMP,  C_MAX,      C_MAX,      1'b1, 24'd3},
        // 0.25 * 2 = 0.5 rounds up; just below stays at 0
        '{13'd2,    13'd2,    WRAP_CLAMP,  24'h004000, 24'h000000, 1'b1, 24'd1},
        '{13'd2,    13'd2,    WRAP_CLAMP,  24'h003FFF, 24'h004000, 1'b1, 24'd2},
        // largest texture, far corner
        '{13'd4096, 13'd4096, WRAP_CLAMP,  C_MAX,      C_MAX,      1'b1, I_MAX},
        '{13'd4096, 13'd4096, WRAP_REPEAT, 24'h010000, 24'h000000, 1'b1, 24'd0},
        '{13'd4096, 13'd4096, WRAP_REPEAT, 24'h00FFFF, 24'h00FFFF, 1'b0, 24'd0},
        '{13'd4096, 13'd4096, WRAP_REPEAT, C_MAX,      C_MAX,      1'b0, 24'd0},
        // zero size behaves as one texel
        '{13'd0,    13'd0,    WRAP_CLAMP,  C_MAX,      C_MAX,      1'b1, 24'd0},
        '{13'd0,    13'd0,    WRAP_REPEAT, 24'h123456, 24'hABCDEF, 1'b1, 24'd0},
        // oversize register saturates at the max dimension
        '{13'd8191, 13'd8191, WRAP_CLAMP,  C_MAX,      C_MAX,      1'b1, I_MAX},
        '{13'd8191, 13'd1,    WRAP_REPEAT, 24'h008000, 24'h5A5A5A, 1'b1, 24'd2048},
        // spare mode code acts as clamp to edge
        '{13'd4096, 13'd4096, WRAP_UNUSED, C_MAX,      C_MAX,      1'b1, I_MAX},
        // mirror: 1.0*4 -> 4 reflects to 3; 2.0 -> 0; 1.5 -> 6 reflects to 1
        '{13'd4,    13'd4,    WRAP_MIRROR, 24'h010000, 24'h000000, 1'b1, 24'd3},
        '{13'd4,    13'd4,    WRAP_MIRROR, 24'h020000, 24'h018000, 1'b1, 24'd4},
        '{13'd4,    13'd4,    WRAP_MIRROR, C_MAX,      C_MAX,      1'b0, 24'd0},
        '{13'd4,    13'd4,    WRAP_REPEAT, 24'h018000, 24'h010000, 1'b1, 24'd2},
        '{13'd4,    13'd4,    WRAP_REPEAT, 24'h01C000, 24'h00E000, 1'b1, 24'd3},
        '{13'd1,    13'd4096, WRAP_MIRROR, 24'h0000FF, C_MAX,      1'b0, 24'd0},
        '{13'd3,    13'd5,    WRAP_MIRROR, 24'h02AAAB, 24'h033333, 1'b0, 24'd0},
        '{13'd4096, 13'd1,    WRAP_CLAMP,  24'h00FFFF, 24'h000000, 1'b1, 24'd4095},
        '{13'd4096, 13'd4096, WRAP_UNUSED, 24'h000001, 24'h7FFFFF, 1'b0, 24'd0}
    };

    // DUT ports; every input starts at a known value
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = REG_TEX_WIDTH;
    logic [CFG_SIZE_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [COORD_W-1:0]    i_coord_u   = '0;
    logic [COORD_W-1:0]    i_coord_v   = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [INDEX_W-1:0]    o_texel_index;

    // bench copy of the texture registers, reset values as in the DUT
    logic [CFG_SIZE_W-1:0] tex_w    = RST_TEX_SIZE;
    logic [CFG_SIZE_W-1:0] tex_h    = RST_TEX_SIZE;
    logic [MODE_W-1:0]     tex_mode = RST_MODE;

    logic [INDEX_W-1:0] pending_index_q [$];   // expected indexes, oldest first
    int  fail_cnt     = 0;
    int  cycle_cnt    = 0;
    bit  hold_off_req = 1'b0;

    texel_address_wrap #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_texel_index (o_texel_index)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // zero acts as one, anything past the max dimension saturates
    function automatic longint unsigned usable_dim(input logic [CFG_SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_DIM)
            return MAX_DIM;
        return s;
    endfunction

    // scale, round half up, then fold into [0, size) per the wrap mode
    function automatic longint unsigned texel_on_axis(input logic [COORD_W-1:0] c,
                                                      input longint unsigned size);
        longint unsigned t;
        t = (longint'(c) * size + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (tex_mode == WRAP_REPEAT) begin
            t = t % size;
        end else if (tex_mode == WRAP_MIRROR) begin
            t = t % (2 * size);
            if (t >= size)
                t = 2 * size - t - 1;
        end else if (t >= size) begin
            // clamp to edge, spare mode code included
            t = size - 1;
        end
        return t;
    endfunction

    function automatic logic [INDEX_W-1:0] texel_index_of(input logic [COORD_W-1:0] u,
                                                          input logic [COORD_W-1:0] v);
        longint unsigned w;
        longint unsigned h;
        longint unsigned row;
        w   = usable_dim(tex_w);
        h   = usable_dim(tex_h);
        row = texel_on_axis(v, h);
        return INDEX_W'(row * w + texel_on_axis(u, w));
    endfunction

    // ---------------------------------------------------------------
    // Register writes and item sender
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_SIZE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            REG_TEX_WIDTH:  tex_w    = data;
            REG_TEX_HEIGHT: tex_h    = data;
            REG_WRAP_MODE:  tex_mode = data[MODE_W-1:0];
            default: ;      // spare slot, no register behind it
        endcase
    endtask

    // hold valid low; the argument n sets the length of the pause
    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // let the pipe run dry before touching the registers
    task automatic drain_pipe();
        pause_sender(1);
        while (pending_index_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic load_texture(input logic [CFG_SIZE_W-1:0] w,
                                input logic [CFG_SIZE_W-1:0] h,
                                input logic [MODE_W-1:0]     mode);
        drain_pipe();
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
        write_reg(REG_WRAP_MODE, {{(CFG_SIZE_W - MODE_W){1'b1}}, mode});
        // junk write to the spare slot must leave everything alone
        write_reg(REG_UNUSED, CFG_SIZE_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one item; valid stays up until the DUT takes it
    task automatic send_coord(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                              input logic known, input logic [INDEX_W-1:0] idx);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_coord_u <= u;
        i_coord_v <= v;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_index_q.push_back(known ? idx : texel_index_of(u, v));
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return COORD_W'($urandom);
            1: return COORD_W'($urandom_range(0, 4 << FRAC_BITS));    // few wraps
            // right around the half-texel point for power-of-two sizes
            2: return COORD_W'(($urandom_range(0, 255) << FRAC_BITS)
                               | $urandom_range(16'h7FF0, 16'h8010));
            3: return $urandom_range(0, 1) ? C_MAX : '0;
            default: return COORD_W'($urandom_range(0, 1 << FRAC_BITS));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: 16-bit ready pattern, redrawn each time it runs out, plus one long hold-off
    // ---------------------------------------------------------------
    initial begin : receiver
        logic [15:0] ready_pat;
        int          pat_pos;
        int          hold_left;
        ready_pat = '1;
        pat_pos   = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD - 1;
                i_ready      <= 1'b0;
            end else begin
                i_ready <= ready_pat[pat_pos];
                pat_pos = pat_pos + 1;
                if (pat_pos == 16) begin
                    pat_pos = 0;
                    case ($urandom_range(0, 3))
                        0: ready_pat = '1;                                  // no stalls
                        1: ready_pat = 16'($urandom);
                        2: ready_pat = 16'($urandom) | 16'($urandom);       // light stalls
                        default: ready_pat = (16'($urandom) & 16'($urandom)) | 16'h0001;
                    endcase
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        logic [INDEX_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_index_q.size() == 0) begin
                fail_cnt = fail_cnt + 1;
                if (fail_cnt <= REPORT_MAX)
                    $display("ERROR: unexpected result index %h at cycle %0d",
                             o_texel_index, cycle_cnt);
            end else begin
                want = pending_index_q.pop_front();
                if (o_texel_index !== want) begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= REPORT_MAX)
                        $display("ERROR: texel_index expected %h got %h at cycle %0d",
                                 want, o_texel_index, cycle_cnt);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("texel_address_wrap verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int burst_left;
        int gap;
        logic [CFG_SIZE_W-1:0] w;
        logic [CFG_SIZE_W-1:0] h;
        logic [MODE_W-1:0]     mode;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; registers only rewritten when a row asks for new setup
        for (int r = 0; r < DIR_N; r++) begin
            if (DIRECTED[r].w != tex_w || DIRECTED[r].h != tex_h
                    || DIRECTED[r].mode != tex_mode)
                load_texture(DIRECTED[r].w, DIRECTED[r].h, DIRECTED[r].mode);
            send_coord(DIRECTED[r].u, DIRECTED[r].v, DIRECTED[r].known, DIRECTED[r].idx);
        end

        // random phases: extremes first, then random setups mostly with small sizes
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin w = 13'd4096; h = 13'd4096; mode = WRAP_REPEAT; end
                1: begin w = 13'd1;    h = 13'd1;    mode = WRAP_MIRROR; end
                2: begin w = 13'd4096; h = 13'd4096; mode = WRAP_MIRROR; end
                3: begin w = 13'd1;    h = 13'd4096; mode = WRAP_CLAMP;  end
                4: begin w = 13'd0;    h = 13'd8191; mode = WRAP_UNUSED; end
                default: begin
                    w    = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 64));
                    h    = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 64));
                    mode = MODE_W'($urandom_range(0, 3));
                end
            endcase
            load_texture(w, h, mode);

            // long receiver hold-off while the sender keeps pushing
            if (p == 2)
                hold_off_req = 1'b1;

            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 10);
                    if (gap != 0)
                        pause_sender(gap);
                    burst_left = $urandom_range(1, 32);
                end
                burst_left = burst_left - 1;
                send_coord(pick_coord(), pick_coord(), 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (LATENCY * 4) @(posedge i_clk);

        if (fail_cnt == 0 && pending_index_q.size() == 0)
            $display("texel_address_wrap verification clean");
        else
            $display("texel_address_wrap verification failed");
        $finish;
    end

endmodule
